@@ design/vmdt_pkg.sv @@
// Shared types and constants for the vector magnitude delta trigger.
package vmdt_pkg;

	localparam int MAG_W = 16;
	localparam logic [MAG_W-1:0] MAG_MAX = 16'hFFFF;

	localparam logic REG_ACCEL_THR = 1'b0;
	localparam logic REG_GYRO_THR  = 1'b1;

	localparam logic CHAN_ACCEL = 1'b0;
	localparam logic CHAN_GYRO  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_START,
		ST_ROOT,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_status_t;

endpackage

@@ design/vmdt_sqrt.sv @@
// Bit-serial integer square root, two radicand bits retired per cycle.
module vmdt_sqrt #(
	parameter int ROOT_W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   radicand,
	output vmdt_pkg::sqrt_status_t status,
	output logic [ROOT_W-1:0]     root
);

	localparam int SUM_W = 2 * ROOT_W;

	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] res_q;
	logic [SUM_W-1:0] bit_q;
	logic             busy_q;
	logic             done_q;
	logic [SUM_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= {2'b01, {(SUM_W-2){1'b0}}};
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

@@ design/vector_magnitude_delta_trigger_core.sv @@
// Top level: send-on-delta trigger on the magnitude of a three-axis sample.
//
// Input channel (in_valid/in_ready) carries one sample beat: channel tag
// (0 accelerometer, 1 gyroscope) and signed x_axis, y_axis, z_axis.
// Output channel (out_valid/out_ready) carries one result beat per sample:
// trigger and magnitude = floor(sqrt(x^2 + y^2 + z^2)), saturated to 16 bits.
// The APB port holds accel_threshold at 0x0 and gyro_threshold at 0x4.
//
// One shared multiplier squares the axes in turn, then follow a start step,
// the bit-serial root steps, a step to take the root and a decide step. A
// new sample is taken only after the previous one has left the decide step.
// in_ready is high only while the sequencer is idle. A finished result sits
// in the output register; the next sample is taken meanwhile, and its result
// waits in the decide step until the receiver takes the earlier beat.
// Reset clears thresholds, baselines and the reported flags, so the first
// sample of each channel always triggers.
module vector_magnitude_delta_trigger_core #(
	parameter int AXIS_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  channel,
	input  logic [AXIS_WIDTH-1:0] x_axis,
	input  logic [AXIS_WIDTH-1:0] y_axis,
	input  logic [AXIS_WIDTH-1:0] z_axis,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  trigger,
	output logic [15:0]           magnitude,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int SUM_W = 2 * AXIS_WIDTH;
	localparam int EXT_W = AXIS_WIDTH + vmdt_pkg::MAG_W;

	vmdt_pkg::state_t state_q, state_d;

	logic [15:0]           accel_thr_q, gyro_thr_q;
	logic [15:0]           accel_base_q, gyro_base_q;
	logic                  accel_seen_q, gyro_seen_q;
	logic                  chan_q;
	logic [AXIS_WIDTH-1:0] x_q, y_q, z_q;
	logic [1:0]            cnt_q;
	logic [SUM_W-1:0]      prod_q, sum_q;
	logic [15:0]           mag_q;
	logic                  out_valid_q, trigger_q;
	logic [15:0]           magnitude_q;

	logic                  in_fire, cfg_wr, load_out, sqrt_start;
	logic [AXIS_WIDTH-1:0] axis_sel, axis_abs;
	logic [SUM_W-1:0]      square;
	logic [AXIS_WIDTH-1:0] root;
	logic [EXT_W-1:0]      root_ext;
	logic [15:0]           mag_sat, base, thr, diff;
	logic                  seen, trig;

	vmdt_pkg::sqrt_status_t sqrt_status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == vmdt_pkg::REG_GYRO_THR) ? {16'b0, gyro_thr_q}
	                                                     : {16'b0, accel_thr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_thr_q <= '0;
			gyro_thr_q  <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == vmdt_pkg::REG_ACCEL_THR) begin
				accel_thr_q <= pwdata[15:0];
			end else begin
				gyro_thr_q <= pwdata[15:0];
			end
		end
	end

	assign in_ready = (state_q == vmdt_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		case (cnt_q)
			2'd0:    axis_sel = x_q;
			2'd1:    axis_sel = y_q;
			default: axis_sel = z_q;
		endcase
		axis_abs = axis_sel[AXIS_WIDTH-1] ? (~axis_sel + 1'b1) : axis_sel;
		square   = axis_abs * axis_abs;
	end

	vmdt_sqrt #(
		.ROOT_W(AXIS_WIDTH)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_q),
		.status   (sqrt_status),
		.root     (root)
	);

	always_comb begin
		root_ext = {{vmdt_pkg::MAG_W{1'b0}}, root};
		mag_sat  = (root_ext > EXT_W'(vmdt_pkg::MAG_MAX)) ? vmdt_pkg::MAG_MAX
		                                                  : root_ext[15:0];
	end

	always_comb begin
		base = (chan_q == vmdt_pkg::CHAN_GYRO) ? gyro_base_q  : accel_base_q;
		thr  = (chan_q == vmdt_pkg::CHAN_GYRO) ? gyro_thr_q   : accel_thr_q;
		seen = (chan_q == vmdt_pkg::CHAN_GYRO) ? gyro_seen_q  : accel_seen_q;
		diff = (mag_q >= base) ? (mag_q - base) : (base - mag_q);
		trig = !seen || (diff >= thr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vmdt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		sqrt_start = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			vmdt_pkg::ST_IDLE: begin
				if (in_valid) state_d = vmdt_pkg::ST_SQUARE;
			end
			vmdt_pkg::ST_SQUARE: begin
				if (cnt_q == 2'd3) state_d = vmdt_pkg::ST_START;
			end
			vmdt_pkg::ST_START: begin
				sqrt_start = 1'b1;
				state_d    = vmdt_pkg::ST_ROOT;
			end
			vmdt_pkg::ST_ROOT: begin
				if (sqrt_status.done) state_d = vmdt_pkg::ST_DECIDE;
			end
			vmdt_pkg::ST_DECIDE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = vmdt_pkg::ST_IDLE;
				end
			end
			default: state_d = vmdt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == vmdt_pkg::ST_SQUARE) begin
			cnt_q <= cnt_q + 2'd1;
		end else begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			chan_q <= channel;
			x_q    <= x_axis;
			y_q    <= y_axis;
			z_q    <= z_axis;
		end
		if (state_q == vmdt_pkg::ST_SQUARE) begin
			prod_q <= square;
			sum_q  <= (cnt_q == 2'd0) ? '0 : (sum_q + prod_q);
		end
		if (sqrt_status.done) begin
			mag_q <= mag_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_base_q <= '0;
			gyro_base_q  <= '0;
			accel_seen_q <= 1'b0;
			gyro_seen_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (trig) begin
					if (chan_q == vmdt_pkg::CHAN_GYRO) begin
						gyro_base_q <= mag_q;
						gyro_seen_q <= 1'b1;
					end else begin
						accel_base_q <= mag_q;
						accel_seen_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			trigger_q   <= trig;
			magnitude_q <= mag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign trigger   = trigger_q;
	assign magnitude = magnitude_q;

`ifndef SYNTH
	a_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_status.done |-> (state_q == vmdt_pkg::ST_ROOT))
		else $error("root finished outside the root phase");

	a_start_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !sqrt_status.busy)
		else $error("root started while the unit was busy");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && state_q == vmdt_pkg::ST_IDLE))
		else $error("decided result not presented");

	a_trig_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && trigger_q) |-> (accel_seen_q || gyro_seen_q))
		else $error("trigger beat without a reported channel");
`endif

endmodule
